// ----- sv/mtqg_pkg.sv -----
// Shared types and constants of the mosaic tile quad generator.
// Used by every module of the block; no dependencies.
`default_nettype none

package mtqg_pkg;

    // Default sizes, handed to the top level parameters
    localparam int unsigned TABLE_DEPTH_DEF = 2048;
    localparam int unsigned MAX_COLUMNS_DEF = 40;
    localparam int unsigned MAX_ROWS_DEF    = 30;

    // Field widths
    localparam int unsigned COL_W     = 6;
    localparam int unsigned ROW_W     = 5;
    localparam int unsigned SV_W      = 16;
    localparam int unsigned GRID_W    = 7;   // clamped grid size, up to 63
    localparam int unsigned IDX_W     = 12;  // column + row * grid
    localparam int unsigned INV_W     = 17;  // Q0.16 reciprocal, 1.0 included
    localparam int unsigned HALF_W    = 20;  // half cell size, Q.8
    localparam int unsigned XY_W      = 21;
    localparam int unsigned UV_W      = 17;
    localparam int unsigned ALPHA_W   = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DW    = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MODE          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_EN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd6;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TILE = 1'b1;

    // Shrink modes (mode three behaves as both axes)
    localparam logic [1:0] MODE_BOTH   = 2'd0;
    localparam logic [1:0] MODE_WIDTH  = 2'd1;
    localparam logic [1:0] MODE_HEIGHT = 2'd2;

    // Fixed point constants
    localparam int unsigned FRAC_ONE   = 65536;
    localparam int unsigned ROUND_HALF = 32768;
    localparam int unsigned POS_SCALE  = 45875;   // 0.7 in Q0.16
    localparam int unsigned WINDOW     = 19661;   // 0.3 in Q0.16
    localparam int unsigned WIN_RECIP  = 218451;  // floor(2^32 / WINDOW)
    localparam int unsigned HALF_PIXEL = 128;
    localparam int unsigned RECIP_N    = 64;      // reciprocal ROM entries

    // Settings derived from the configuration registers
    typedef struct packed {
        logic [1:0]        mode;
        logic [15:0]       intensity;
        logic              alpha_en;
        logic [GRID_W-1:0] grid_cols;
        logic [INV_W-1:0]  inv_w;
        logic [INV_W-1:0]  inv_h;
        logic [HALF_W-1:0] half_w;
        logic [HALF_W-1:0] half_h;
    } t_cfg;

    // Corners of one finished quad
    typedef struct packed {
        logic signed [XY_W-1:0] x0;
        logic signed [XY_W-1:0] x1;
        logic signed [XY_W-1:0] y0;
        logic signed [XY_W-1:0] y1;
        logic [UV_W-1:0]        u0;
        logic [UV_W-1:0]        u1;
        logic [UV_W-1:0]        v0;
        logic [UV_W-1:0]        v1;
        logic [ALPHA_W-1:0]     alpha;
    } t_quad;

endpackage

`default_nettype wire

// ----- sv/mtqg_cfg.sv -----
// Configuration registers, reciprocal ROM and derived cell sizes.
// Depends on mtqg_pkg.
`default_nettype none

module mtqg_cfg #(
    parameter int unsigned MAX_COLUMNS = mtqg_pkg::MAX_COLUMNS_DEF,
    parameter int unsigned MAX_ROWS    = mtqg_pkg::MAX_ROWS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [mtqg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [mtqg_pkg::CFG_DW-1:0]        i_cfg_data,
    output mtqg_pkg::t_cfg                     o_cfg,
    output logic                               o_busy
);

    localparam logic [1:0] SETTLE = 2'd2;

    logic [1:0]  r_mode;
    logic [15:0] r_intensity;
    logic        r_alpha_en;
    logic [5:0]  r_grid_width;
    logic [4:0]  r_grid_height;
    logic [12:0] r_screen_width;
    logic [12:0] r_screen_height;
    logic [1:0]  r_settle;

    logic [mtqg_pkg::GRID_W-1:0] w_cols;
    logic [mtqg_pkg::GRID_W-1:0] w_rows;
    logic [mtqg_pkg::INV_W-1:0]  w_rom [mtqg_pkg::RECIP_N];

    logic [mtqg_pkg::GRID_W-1:0] r_cols;
    logic [mtqg_pkg::INV_W-1:0]  r_inv_w;
    logic [mtqg_pkg::INV_W-1:0]  r_inv_h;
    logic [mtqg_pkg::HALF_W-1:0] r_half_w;
    logic [mtqg_pkg::HALF_W-1:0] r_half_h;
    logic [29:0]                 n_half_w;
    logic [29:0]                 n_half_h;

    assign o_cfg_ready = 1'b1;

    // Register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= mtqg_pkg::MODE_BOTH;
            r_intensity     <= 16'd0;
            r_alpha_en      <= 1'b0;
            r_grid_width    <= 6'd14;
            r_grid_height   <= 5'd10;
            r_screen_width  <= 13'd640;
            r_screen_height <= 13'd480;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mtqg_pkg::CFG_MODE:          r_mode          <= i_cfg_data[1:0];
                mtqg_pkg::CFG_INTENSITY:     r_intensity     <= i_cfg_data;
                mtqg_pkg::CFG_ALPHA_EN:      r_alpha_en      <= i_cfg_data[0];
                mtqg_pkg::CFG_GRID_WIDTH:    r_grid_width    <= i_cfg_data[5:0];
                mtqg_pkg::CFG_GRID_HEIGHT:   r_grid_height   <= i_cfg_data[4:0];
                mtqg_pkg::CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data[12:0];
                mtqg_pkg::CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Settle counter: busy after any write while derived values pass the reciprocal and half size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= SETTLE;
        end else if (i_cfg_valid) begin
            r_settle <= SETTLE;
        end else if (r_settle != 2'd0) begin
            r_settle <= r_settle - 2'd1;
        end
    end

    assign o_busy = (r_settle != 2'd0);

    // Reciprocal ROM: entry n holds round(1/(n+1)) in Q0.16
    for (genvar n = 0; n < mtqg_pkg::RECIP_N; n++) begin : g_rom
        localparam int unsigned Inv = (mtqg_pkg::FRAC_ONE + (n + 1) / 2) / (n + 1);
        assign w_rom[n] = mtqg_pkg::INV_W'(Inv);
    end

    // Grid clamp to 1..MAX
    always_comb begin
        if (r_grid_width == 6'd0) begin
            w_cols = 7'd1;
        end else if (7'(r_grid_width) > 7'(MAX_COLUMNS)) begin
            w_cols = 7'(MAX_COLUMNS);
        end else begin
            w_cols = 7'(r_grid_width);
        end
        if (r_grid_height == 5'd0) begin
            w_rows = 7'd1;
        end else if (7'(r_grid_height) > 7'(MAX_ROWS)) begin
            w_rows = 7'(MAX_ROWS);
        end else begin
            w_rows = 7'(r_grid_height);
        end
    end

    // Half cell size, Q.8, rounded
    assign n_half_w = (30'(r_screen_width) * 30'(r_inv_w) + 30'd256) >> 9;
    assign n_half_h = (30'(r_screen_height) * 30'(r_inv_h) + 30'd256) >> 9;

    always_ff @(posedge i_clk) begin
        r_cols   <= w_cols;
        r_inv_w  <= w_rom[6'(w_cols - 7'd1)];
        r_inv_h  <= w_rom[6'(w_rows - 7'd1)];
        r_half_w <= n_half_w[mtqg_pkg::HALF_W-1:0];
        r_half_h <= n_half_h[mtqg_pkg::HALF_W-1:0];
    end

    always_comb begin
        o_cfg.mode      = r_mode;
        o_cfg.intensity = r_intensity;
        o_cfg.alpha_en  = r_alpha_en;
        o_cfg.grid_cols = r_cols;
        o_cfg.inv_w     = r_inv_w;
        o_cfg.inv_h     = r_inv_h;
        o_cfg.half_w    = r_half_w;
        o_cfg.half_h    = r_half_h;
    end

endmodule

`default_nettype wire

// ----- sv/mtqg_tile_mem.sv -----
// Tile start value store: single port synchronous RAM, registered read.
// Depends on mtqg_pkg.
`default_nettype none

module mtqg_tile_mem #(
    parameter int unsigned TABLE_DEPTH = mtqg_pkg::TABLE_DEPTH_DEF,
    localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
    input  wire                          i_clk,
    input  wire                          i_we,
    input  wire                          i_re,
    input  wire  [AW-1:0]                i_addr,
    input  wire  [mtqg_pkg::SV_W-1:0]    i_wdata,
    output logic [mtqg_pkg::SV_W-1:0]    o_rdata
);

    logic [mtqg_pkg::SV_W-1:0] r_mem [TABLE_DEPTH];
    logic [mtqg_pkg::SV_W-1:0] r_rdata;

    // One item a cycle, so a load and a read never meet in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/mtqg_geom.sv -----
// Quad geometry pipeline: shrink factor, centre, corners, texture coords.
// Six register stages, all held by one enable. Depends on mtqg_pkg.
`default_nettype none

module mtqg_geom (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_en,
    input  wire                           i_valid,
    input  wire  [mtqg_pkg::COL_W-1:0]    i_column,
    input  wire  [mtqg_pkg::ROW_W-1:0]    i_row,
    input  wire                           i_in_range,
    input  wire  [mtqg_pkg::SV_W-1:0]     i_rdata,
    input  mtqg_pkg::t_cfg                i_cfg,
    output logic                          o_valid,
    output mtqg_pkg::t_quad               o_quad
);

    // Saturate Q.8 coordinate to the output range
    function automatic logic signed [mtqg_pkg::XY_W-1:0] sat_xy(input logic signed [28:0] v);
        logic signed [mtqg_pkg::XY_W-1:0] res;
        if (v > 29'sd1048575) begin
            res = 21'sd1048575;
        end else if (v < -29'sd1048576) begin
            res = -21'sd1048576;
        end else begin
            res = v[mtqg_pkg::XY_W-1:0];
        end
        return res;
    endfunction

    // Saturate texture coordinate to 1.0
    function automatic logic [mtqg_pkg::UV_W-1:0] sat_uv(input logic [23:0] v);
        logic [mtqg_pkg::UV_W-1:0] res;
        if (v > 24'(mtqg_pkg::FRAC_ONE)) begin
            res = mtqg_pkg::UV_W'(mtqg_pkg::FRAC_ONE);
        end else begin
            res = v[mtqg_pkg::UV_W-1:0];
        end
        return res;
    endfunction

    // Stage 1: tile position, RAM read in flight
    logic                       r_v1;
    logic [mtqg_pkg::COL_W-1:0] r_col1;
    logic [mtqg_pkg::ROW_W-1:0] r_row1;
    logic                       r_inr1;

    // Stage 2: start * 0.7, cell centre
    logic                       r_v2;
    logic [mtqg_pkg::COL_W-1:0] r_col2;
    logic [mtqg_pkg::ROW_W-1:0] r_row2;
    logic [15:0]                r_ini2;
    logic [26:0]                r_cx2;
    logic [26:0]                r_cy2;

    // Stage 3: window test, quotient estimate, texture coords
    logic                       r_v3;
    logic [26:0]                r_cx3;
    logic [26:0]                r_cy3;
    logic [mtqg_pkg::UV_W-1:0]  r_u0_3, r_u1_3, r_v0_3, r_v1_3;
    logic                       r_le3;
    logic                       r_gt3;
    logic [14:0]                r_d3;
    logic [16:0]                r_qe3;

    // Stage 4: shrink factor
    logic                       r_v4;
    logic [26:0]                r_cx4;
    logic [26:0]                r_cy4;
    logic [mtqg_pkg::UV_W-1:0]  r_u0_4, r_u1_4, r_v0_4, r_v1_4;
    logic [16:0]                r_size4;

    // Stage 5: half extents and alpha
    logic                        r_v5;
    logic [26:0]                 r_cx5;
    logic [26:0]                 r_cy5;
    logic [mtqg_pkg::UV_W-1:0]   r_u0_5, r_u1_5, r_v0_5, r_v1_5;
    logic [mtqg_pkg::HALF_W-1:0] r_dx5;
    logic [mtqg_pkg::HALF_W-1:0] r_dy5;
    logic [mtqg_pkg::ALPHA_W-1:0] r_alpha5;

    // Stage 6: finished quad
    logic              r_v6;
    mtqg_pkg::t_quad   r_quad6;

    logic [mtqg_pkg::SV_W-1:0] w_start;
    logic [31:0]               w_ini_prod;
    logic [16:0]               w_end;
    logic [16:0]               w_diff;
    logic [32:0]               w_qe_prod;
    logic [31:0]               w_rem;
    logic [16:0]               w_q;
    logic [16:0]               n_size;
    logic [36:0]               w_dx_prod;
    logic [36:0]               w_dy_prod;
    logic [24:0]               w_alpha_prod;
    logic signed [28:0]        w_x0, w_x1, w_y0, w_y1;

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // Stage 2 logic
    assign w_start    = r_inr1 ? i_rdata : '0;
    assign w_ini_prod = 32'(w_start) * 32'(mtqg_pkg::POS_SCALE) + 32'(mtqg_pkg::ROUND_HALF);

    // Stage 3 logic: window end, distance into window, reciprocal estimate
    assign w_end     = 17'(r_ini2) + 17'(mtqg_pkg::WINDOW);
    assign w_diff    = w_end - 17'(i_cfg.intensity);
    assign w_qe_prod = 33'(w_diff[14:0]) * 33'(mtqg_pkg::WIN_RECIP);

    // Stage 4 logic: estimate is exact or one low
    assign w_rem = {1'b0, r_d3, 16'd0} - 32'(r_qe3) * 32'(mtqg_pkg::WINDOW);
    assign w_q   = r_qe3 + ((w_rem >= 32'(mtqg_pkg::WINDOW)) ? 17'd1 : 17'd0);

    always_comb begin
        priority if (r_le3) begin
            n_size = 17'(mtqg_pkg::FRAC_ONE);
        end else if (r_gt3) begin
            n_size = 17'd0;
        end else begin
            n_size = w_q;
        end
    end

    // Stage 5 logic
    assign w_dx_prod    = 37'(r_size4) * 37'(i_cfg.half_w) + 37'(mtqg_pkg::ROUND_HALF);
    assign w_dy_prod    = 37'(r_size4) * 37'(i_cfg.half_h) + 37'(mtqg_pkg::ROUND_HALF);
    assign w_alpha_prod = {r_size4, 8'd0} - 25'(r_size4);

    // Stage 6 logic: corners less half a pixel
    assign w_x0 = $signed({2'b00, r_cx5}) - $signed({9'd0, r_dx5}) - 29'sd128;
    assign w_x1 = $signed({2'b00, r_cx5}) + $signed({9'd0, r_dx5}) - 29'sd128;
    assign w_y0 = $signed({2'b00, r_cy5}) - $signed({9'd0, r_dy5}) - 29'sd128;
    assign w_y1 = $signed({2'b00, r_cy5}) + $signed({9'd0, r_dy5}) - 29'sd128;

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_col1 <= i_column;
            r_row1 <= i_row;
            r_inr1 <= i_in_range;

            r_col2 <= r_col1;
            r_row2 <= r_row1;
            r_ini2 <= w_ini_prod[31:16];
            r_cx2  <= 27'({r_col1, 1'b1}) * 27'(i_cfg.half_w);
            r_cy2  <= 27'({r_row1, 1'b1}) * 27'(i_cfg.half_h);

            r_cx3  <= r_cx2;
            r_cy3  <= r_cy2;
            r_u0_3 <= sat_uv(24'(r_col2) * 24'(i_cfg.inv_w));
            r_u1_3 <= sat_uv((24'(r_col2) + 24'd1) * 24'(i_cfg.inv_w));
            r_v0_3 <= sat_uv(24'(r_row2) * 24'(i_cfg.inv_h));
            r_v1_3 <= sat_uv((24'(r_row2) + 24'd1) * 24'(i_cfg.inv_h));
            r_le3  <= (i_cfg.intensity <= r_ini2);
            r_gt3  <= (17'(i_cfg.intensity) > w_end);
            r_d3   <= w_diff[14:0];
            r_qe3  <= w_qe_prod[32:16];

            r_cx4   <= r_cx3;
            r_cy4   <= r_cy3;
            r_u0_4  <= r_u0_3;
            r_u1_4  <= r_u1_3;
            r_v0_4  <= r_v0_3;
            r_v1_4  <= r_v1_3;
            r_size4 <= n_size;

            r_cx5  <= r_cx4;
            r_cy5  <= r_cy4;
            r_u0_5 <= r_u0_4;
            r_u1_5 <= r_u1_4;
            r_v0_5 <= r_v0_4;
            r_v1_5 <= r_v1_4;
            r_dx5  <= (i_cfg.mode == mtqg_pkg::MODE_HEIGHT) ? i_cfg.half_w
                                                            : w_dx_prod[35:16];
            r_dy5  <= (i_cfg.mode == mtqg_pkg::MODE_WIDTH) ? i_cfg.half_h
                                                           : w_dy_prod[35:16];
            r_alpha5 <= i_cfg.alpha_en ? w_alpha_prod[23:16] : 8'hFF;

            r_quad6.x0    <= sat_xy(w_x0);
            r_quad6.x1    <= sat_xy(w_x1);
            r_quad6.y0    <= sat_xy(w_y0);
            r_quad6.y1    <= sat_xy(w_y1);
            r_quad6.u0    <= r_u0_5;
            r_quad6.u1    <= r_u1_5;
            r_quad6.v0    <= r_v0_5;
            r_quad6.v1    <= r_v1_5;
            r_quad6.alpha <= r_alpha5;
        end
    end

    assign o_valid = r_v6;
    assign o_quad  = r_quad6;

endmodule

`default_nettype wire

// ----- sv/mtqg_emit.sv -----
// Vertex sequencer: holds one quad and sends its six vertices in order.
// Depends on mtqg_pkg.
`default_nettype none

module mtqg_emit (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    input  mtqg_pkg::t_quad                      i_quad,
    output logic                                 o_take,
    output logic                                 o_valid,
    input  wire                                  i_stall,
    output logic signed [mtqg_pkg::XY_W-1:0]     o_vertex_x,
    output logic signed [mtqg_pkg::XY_W-1:0]     o_vertex_y,
    output logic [mtqg_pkg::UV_W-1:0]            o_tex_u,
    output logic [mtqg_pkg::UV_W-1:0]            o_tex_v,
    output logic [mtqg_pkg::ALPHA_W-1:0]         o_alpha,
    output logic                                 o_last_vertex
);

    localparam logic [2:0] LAST_VTX = 3'd5;

    logic            r_busy;
    logic [2:0]      r_cnt;
    mtqg_pkg::t_quad r_quad;

    logic w_last;
    logic w_pop;
    logic w_sel_x;
    logic w_sel_y;

    assign w_last = (r_cnt == LAST_VTX);
    assign w_pop  = r_busy && !i_stall;
    assign o_take = !r_busy || (w_pop && w_last);

    // Vertex counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
        end else if (i_valid && o_take) begin
            r_busy <= 1'b1;
            r_cnt  <= 3'd0;
        end else if (w_pop) begin
            r_busy <= !w_last;
            r_cnt  <= r_cnt + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_take) begin
            r_quad <= i_quad;
        end
    end

    // Corner select: triangles (0,0)(1,0)(1,1) and (0,0)(1,1)(0,1)
    assign w_sel_x = (r_cnt == 3'd1) || (r_cnt == 3'd2) || (r_cnt == 3'd4);
    assign w_sel_y = (r_cnt == 3'd2) || (r_cnt == 3'd4) || (r_cnt == 3'd5);

    assign o_valid       = r_busy;
    assign o_vertex_x    = w_sel_x ? r_quad.x1 : r_quad.x0;
    assign o_vertex_y    = w_sel_y ? r_quad.y1 : r_quad.y0;
    assign o_tex_u       = w_sel_x ? r_quad.u1 : r_quad.u0;
    assign o_tex_v       = w_sel_y ? r_quad.v1 : r_quad.v0;
    assign o_alpha       = r_quad.alpha;
    assign o_last_vertex = w_last;

endmodule

`default_nettype wire

// ----- sv/mosaic_tile_quad_generator.sv -----
// Mosaic tile quad generator: tile start value store and quad vertex output.
// Loads may follow every cycle unless the input is stalled; a tile's first
// vertex leaves after the six geometry stages and the sequencer register,
// and the single result channel, six vertices per tile, paces tiles.
// Reset restores register defaults; table contents stay undefined until
// loaded. Input is stalled after reset and after each cfg write until settled.
`default_nettype none

module mosaic_tile_quad_generator #(
    parameter int unsigned TABLE_DEPTH = mtqg_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned MAX_COLUMNS = mtqg_pkg::MAX_COLUMNS_DEF,
    parameter int unsigned MAX_ROWS    = mtqg_pkg::MAX_ROWS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // configuration write
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [mtqg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [mtqg_pkg::CFG_DW-1:0]          i_cfg_data,
    // input items
    input  wire                                  i_valid,
    output logic                                 o_stall,
    input  wire                                  i_command,
    input  wire  [mtqg_pkg::COL_W-1:0]           i_column,
    input  wire  [mtqg_pkg::ROW_W-1:0]           i_row,
    input  wire  [mtqg_pkg::SV_W-1:0]            i_start_value,
    // result items
    output logic                                 o_valid,
    input  wire                                  i_stall,
    output logic signed [mtqg_pkg::XY_W-1:0]     o_vertex_x,
    output logic signed [mtqg_pkg::XY_W-1:0]     o_vertex_y,
    output logic [mtqg_pkg::UV_W-1:0]            o_tex_u,
    output logic [mtqg_pkg::UV_W-1:0]            o_tex_v,
    output logic [mtqg_pkg::ALPHA_W-1:0]         o_alpha,
    output logic                                 o_last_vertex
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);

    mtqg_pkg::t_cfg  w_cfg;
    mtqg_pkg::t_quad w_quad;
    logic            w_cfg_busy;
    logic            w_geom_valid;
    logic            w_take;
    logic            w_en;
    logic            w_acc;
    logic            w_acc_tile;
    logic            w_acc_load;
    logic [mtqg_pkg::IDX_W-1:0] w_idx;
    logic            w_in_range;
    logic [mtqg_pkg::SV_W-1:0]  w_rdata;

    // Pipeline moves unless its last stage holds a quad the sequencer can't take
    assign w_en    = !w_geom_valid || w_take;
    assign o_stall = !w_en || w_cfg_busy;

    assign w_acc      = i_valid && !o_stall;
    assign w_acc_tile = w_acc && (i_command == mtqg_pkg::CMD_TILE);
    assign w_acc_load = w_acc && (i_command == mtqg_pkg::CMD_LOAD) && w_in_range;

    // Table index
    assign w_idx      = 12'(i_row) * 12'(w_cfg.grid_cols) + 12'(i_column);
    assign w_in_range = (13'(w_idx) < 13'(TABLE_DEPTH));

    mtqg_cfg #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg),
        .o_busy      (w_cfg_busy)
    );

    mtqg_tile_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_acc_load),
        .i_re    (w_acc_tile),
        .i_addr  (w_idx[AW-1:0]),
        .i_wdata (i_start_value),
        .o_rdata (w_rdata)
    );

    mtqg_geom u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_acc_tile),
        .i_column   (i_column),
        .i_row      (i_row),
        .i_in_range (w_in_range),
        .i_rdata    (w_rdata),
        .i_cfg      (w_cfg),
        .o_valid    (w_geom_valid),
        .o_quad     (w_quad)
    );

    mtqg_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_geom_valid),
        .i_quad        (w_quad),
        .o_take        (w_take),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_vertex_x    (o_vertex_x),
        .o_vertex_y    (o_vertex_y),
        .o_tex_u       (o_tex_u),
        .o_tex_v       (o_tex_v),
        .o_alpha       (o_alpha),
        .o_last_vertex (o_last_vertex)
    );

    // A config write holds off input items while derived values settle
    a_cfg_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> o_stall)
        else $error("item accepted before configuration settled");

    // A quad's vertices follow each other without a gap
    a_quad_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_vertex |=> o_valid)
        else $error("quad vertex sequence broken");

    // After a last vertex the next vertex starts a new quad
    a_quad_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last_vertex |=> !o_last_vertex)
        else $error("last vertex repeated");

endmodule

`default_nettype wire
